FILE: src/random_key_tour_decoder_defines.svh
// Assertion helpers for the random key tour decoder.
`ifndef RANDOM_KEY_TOUR_DECODER_DEFINES_SVH
`define RANDOM_KEY_TOUR_DECODER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define RKTD_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the same cycle.
`define RKTD_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/rktd_pkg.sv
package rktd_pkg;

  localparam int LABEL_BITS = 6;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT_DOWN,
    OP_DROP_TOP
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [LABEL_BITS-1:0] label;
  } cell_ctrl_t;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } dec_state_t;

endpackage

FILE: src/rktd_cell.sv
module rktd_cell #(
  parameter int KW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rktd_pkg::cell_ctrl_t             ctrl,
  input  logic [KW-1:0]                    new_key,
  input  logic [KW-1:0]                    lower_key,
  input  logic [rktd_pkg::LABEL_BITS-1:0]  lower_label,
  input  logic                             lower_valid,
  input  logic                             lower_gt,
  input  logic [KW-1:0]                    upper_key,
  input  logic [rktd_pkg::LABEL_BITS-1:0]  upper_label,
  input  logic                             upper_valid,
  output logic [KW-1:0]                    key,
  output logic [rktd_pkg::LABEL_BITS-1:0]  label,
  output logic                             valid,
  output logic                             gt,
  output logic                             top
);

  logic [KW-1:0]                   key_next;
  logic [rktd_pkg::LABEL_BITS-1:0] label_next;
  logic                            valid_next;

  // An empty cell counts as holding an infinitely large key.
  assign gt  = !valid || (key > new_key);
  assign top = valid && !upper_valid;

  always_comb begin
    key_next   = key;
    label_next = label;
    valid_next = valid;
    case (ctrl.op)
      rktd_pkg::OP_INSERT: begin
        if (gt) begin
          if (lower_gt) begin
            key_next   = lower_key;
            label_next = lower_label;
            valid_next = lower_valid;
          end else begin
            key_next   = new_key;
            label_next = ctrl.label;
            valid_next = 1'b1;
          end
        end
      end
      rktd_pkg::OP_SHIFT_DOWN: begin
        key_next   = upper_key;
        label_next = upper_label;
        valid_next = upper_valid;
      end
      rktd_pkg::OP_DROP_TOP: begin
        if (top) begin
          valid_next = 1'b0;
        end
      end
      default: begin
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key   <= key_next;
    label <= label_next;
  end

endmodule

FILE: src/rktd_chain.sv
module rktd_chain #(
  parameter int N  = 32,
  parameter int KW = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rktd_pkg::cell_ctrl_t             ctrl,
  input  logic [KW-1:0]                    new_key,
  output logic [rktd_pkg::LABEL_BITS-1:0]  head_label,
  output logic [rktd_pkg::LABEL_BITS-1:0]  top_label,
  output logic [N-1:0]                     valid_vec
);

  logic [KW-1:0]                   key_a   [N];
  logic [rktd_pkg::LABEL_BITS-1:0] label_a [N];
  logic [N-1:0]                    gt_vec;
  logic [N-1:0]                    top_vec;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [KW-1:0]                   lo_key;
    logic [rktd_pkg::LABEL_BITS-1:0] lo_label;
    logic                            lo_valid;
    logic                            lo_gt;
    logic [KW-1:0]                   up_key;
    logic [rktd_pkg::LABEL_BITS-1:0] up_label;
    logic                            up_valid;

    if (i == 0) begin : g_first
      assign lo_key   = '0;
      assign lo_label = '0;
      assign lo_valid = 1'b0;
      assign lo_gt    = 1'b0;
    end else begin : g_inner_lo
      assign lo_key   = key_a[i-1];
      assign lo_label = label_a[i-1];
      assign lo_valid = valid_vec[i-1];
      assign lo_gt    = gt_vec[i-1];
    end

    if (i == N - 1) begin : g_last
      assign up_key   = '0;
      assign up_label = '0;
      assign up_valid = 1'b0;
    end else begin : g_inner_up
      assign up_key   = key_a[i+1];
      assign up_label = label_a[i+1];
      assign up_valid = valid_vec[i+1];
    end

    rktd_cell #(.KW(KW)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_key     (new_key),
      .lower_key   (lo_key),
      .lower_label (lo_label),
      .lower_valid (lo_valid),
      .lower_gt    (lo_gt),
      .upper_key   (up_key),
      .upper_label (up_label),
      .upper_valid (up_valid),
      .key         (key_a[i]),
      .label       (label_a[i]),
      .valid       (valid_vec[i]),
      .gt          (gt_vec[i]),
      .top         (top_vec[i])
    );
  end

  assign head_label = label_a[0];

  // Valid cells are contiguous from cell 0, so at most one top flag is set.
  always_comb begin
    top_label = '0;
    for (int i = 0; i < N; i++) begin
      top_label = top_label | (label_a[i] & {rktd_pkg::LABEL_BITS{top_vec[i]}});
    end
  end

endmodule

FILE: src/random_key_tour_decoder.sv
// Random key tour decoder.
// Input channel (key, last_key; key_valid / key_stall): one random key per
// transaction. The n-th key of a run labels vertex n; last_key closes the run.
// Each key is inserted into a sorted row of MAX_KEYS cells in the cycle it is
// taken, so keys are accepted one per cycle while a run is loading.
// Output channel (vertex, last_vertex, overflow; vertex_valid / vertex_stall):
// after the closing key the tour comes out as n+1 transactions: vertex 0, then
// the labels in key order (reversed if the first label exceeds the last one).
// The first result is registered after the closing key has moved the state to
// emitting, and the rest follow one per cycle while vertex_stall is low.
// key_stall is high while a tour is being emitted. Holding vertex_stall high
// freezes the output register and the row of cells; nothing is lost.
// Keys beyond MAX_KEYS are dropped and flagged on every result of that tour.
// Reset (rst, synchronous) empties the row and returns to loading.
module random_key_tour_decoder #(
  parameter int MAX_KEYS = 32,
  parameter int KEY_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             key_valid,
  output logic                             key_stall,
  input  logic [31:0]                      key,
  input  logic                             last_key,
  output logic                             vertex_valid,
  input  logic                             vertex_stall,
  output logic [rktd_pkg::LABEL_BITS-1:0]  vertex,
  output logic                             last_vertex,
  output logic                             overflow
);

`include "random_key_tour_decoder_defines.svh"

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int CW = $clog2(MAX_KEYS + 1);

  rktd_pkg::dec_state_t state, state_next;
  logic [CW-1:0]        key_count, key_count_next;
  logic                 overflow_seen, overflow_seen_next;
  logic                 zero_pending, zero_pending_next;
  logic                 reverse, reverse_next;
  logic                 vertex_valid_next;

  rktd_pkg::cell_ctrl_t            ctrl;
  logic [KW-1:0]                   new_key;
  logic [rktd_pkg::LABEL_BITS-1:0] head_label;
  logic [rktd_pkg::LABEL_BITS-1:0] top_label;
  logic [rktd_pkg::LABEL_BITS-1:0] emit_label;
  logic [MAX_KEYS-1:0]             valid_vec;

  logic key_acc;
  logic advance;
  logic full;
  logic finishing;

  assign new_key   = key[KW-1:0];
  assign full      = (key_count == CW'(MAX_KEYS));
  assign key_acc   = key_valid && !key_stall;
  assign advance   = (state == rktd_pkg::ST_EMIT) && (!vertex_valid || !vertex_stall);
  assign emit_label = reverse ? top_label : head_label;
  assign finishing = advance && (zero_pending ? (key_count == '0)
                                              : (key_count == CW'(1)));

  rktd_chain #(.N(MAX_KEYS), .KW(KW)) u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .new_key    (new_key),
    .head_label (head_label),
    .top_label  (top_label),
    .valid_vec  (valid_vec)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rktd_pkg::ST_LOAD: begin
        if (key_acc && last_key) begin
          state_next = rktd_pkg::ST_EMIT;
        end
      end
      rktd_pkg::ST_EMIT: begin
        if (finishing) begin
          state_next = rktd_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = rktd_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    key_stall          = (state != rktd_pkg::ST_LOAD);
    ctrl.op            = rktd_pkg::OP_HOLD;
    ctrl.label         = rktd_pkg::LABEL_BITS'(key_count) + 1'b1;
    key_count_next     = key_count;
    overflow_seen_next = overflow_seen;
    zero_pending_next  = zero_pending;
    reverse_next       = reverse;
    vertex_valid_next  = vertex_valid && vertex_stall;

    if (key_acc) begin
      if (full) begin
        overflow_seen_next = 1'b1;
      end else begin
        ctrl.op        = rktd_pkg::OP_INSERT;
        key_count_next = key_count + 1'b1;
      end
      if (last_key) begin
        zero_pending_next = 1'b1;
      end
    end

    if (advance) begin
      vertex_valid_next = 1'b1;
      if (zero_pending) begin
        zero_pending_next = 1'b0;
        reverse_next      = (key_count != '0) && (head_label > top_label);
      end else begin
        ctrl.op        = reverse ? rktd_pkg::OP_DROP_TOP : rktd_pkg::OP_SHIFT_DOWN;
        key_count_next = key_count - 1'b1;
      end
      if (finishing) begin
        overflow_seen_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= rktd_pkg::ST_LOAD;
      key_count     <= '0;
      overflow_seen <= 1'b0;
      zero_pending  <= 1'b0;
      reverse       <= 1'b0;
      vertex_valid  <= 1'b0;
    end else begin
      state         <= state_next;
      key_count     <= key_count_next;
      overflow_seen <= overflow_seen_next;
      zero_pending  <= zero_pending_next;
      reverse       <= reverse_next;
      vertex_valid  <= vertex_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vertex      <= zero_pending ? '0 : emit_label;
      last_vertex <= finishing;
      overflow    <= overflow_seen;
    end
  end

  `RKTD_ALWAYS(a_count_matches_cells, $countones(valid_vec) == int'(key_count), "cell count mismatch")
  `RKTD_ALWAYS(a_cells_contiguous, (valid_vec & (valid_vec + MAX_KEYS'(1))) == '0, "gap in cell row")
  `RKTD_IMPLIES(a_emit_has_keys, state == rktd_pkg::ST_EMIT && !zero_pending, key_count != '0, "label emit with empty row")
  `RKTD_IMPLIES(a_count_bound, 1'b1, key_count <= CW'(MAX_KEYS), "count beyond capacity")

endmodule

FILE: bench/tb_random_key_tour_decoder.sv
module tb_random_key_tour_decoder;

  localparam int MAX_KEYS = 32;
  localparam int KEY_BITS = 32;
  localparam int LW       = rktd_pkg::LABEL_BITS;

  typedef struct packed {
    logic [31:0] key;
    logic        fin;
  } key_item_t;

  typedef struct packed {
    logic [LW-1:0] vertex;
    logic          last_vertex;
    logic          overflow;
  } tour_entry_t;

  logic          clk = 1'b0;
  logic          rst;
  logic          key_valid;
  logic          key_stall;
  logic [31:0]   key;
  logic          last_key;
  logic          vertex_valid;
  logic          vertex_stall;
  logic [LW-1:0] vertex;
  logic          last_vertex;
  logic          overflow;

  random_key_tour_decoder #(
    .MAX_KEYS(MAX_KEYS),
    .KEY_BITS(KEY_BITS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key         (key),
    .last_key    (last_key),
    .vertex_valid(vertex_valid),
    .vertex_stall(vertex_stall),
    .vertex      (vertex),
    .last_vertex (last_vertex),
    .overflow    (overflow)
  );

  always #4 clk = ~clk;

  key_item_t   pending_keys[$];
  tour_entry_t tour_q[$];

  // Sorted chain as the block should hold it
  logic [31:0]   chain_keys[MAX_KEYS];
  logic [LW-1:0] chain_labels[MAX_KEYS];
  int unsigned   held;
  bit            dropped;

  int unsigned   sent;
  int unsigned   fails;
  bit            key_taken;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;

  // Insert one accepted key; on the closing key queue the whole tour.
  task automatic take_key(input logic [31:0] k, input logic fin);
    int pos;
    int src;
    bit rev;
    if (held < MAX_KEYS) begin
      pos = held;
      while (pos > 0 && chain_keys[pos-1] > k) begin
        chain_keys[pos]   = chain_keys[pos-1];
        chain_labels[pos] = chain_labels[pos-1];
        pos--;
      end
      chain_keys[pos]   = k;
      chain_labels[pos] = LW'(held + 1);
      held++;
    end else begin
      dropped = 1'b1;
    end
    if (fin) begin
      rev = held > 0 && chain_labels[0] > chain_labels[held-1];
      tour_q.push_back(tour_entry_t'{vertex: '0, last_vertex: held == 0, overflow: dropped});
      for (int i = 0; i < held; i++) begin
        src = rev ? held - 1 - i : i;
        tour_q.push_back(tour_entry_t'{vertex: chain_labels[src],
                                       last_vertex: i + 1 == held,
                                       overflow: dropped});
      end
      held    = 0;
      dropped = 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 3);          // dense ties
      3: return 32'hFFFF_FFFC + $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_run(input int len);
    for (int i = 0; i < len; i++)
      pending_keys.push_back(key_item_t'{key: pick_key(), fin: i == len - 1});
  endtask

  task automatic add_fixed(input logic [31:0] k, input logic fin);
    pending_keys.push_back(key_item_t'{key: k, fin: fin});
  endtask

  // Driver: new transaction at the falling edge once the last one was taken
  always @(negedge clk) begin
    key_item_t nxt;
    case ((sent / 20) % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
    if (rst) begin
      key_valid <= 1'b0;
    end else if (!key_valid || key_taken) begin
      if (pending_keys.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_keys.pop_front();
        key_valid <= 1'b1;
        key       <= nxt.key;
        last_key  <= nxt.fin;
        sent++;
      end else begin
        key_valid <= 1'b0;
      end
    end
    vertex_stall <= $urandom_range(0, 99) < recv_stall_pct;
  end

  // Monitor and predictor share the rising edge; prediction goes first
  always @(posedge clk) begin
    tour_entry_t exp_e;
    key_taken <= !rst && key_valid && !key_stall;
    if (!rst && key_valid && !key_stall)
      take_key(key, last_key);
    if (!rst && vertex_valid && !vertex_stall) begin
      if (tour_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: vertex=%0d last_vertex=%0b overflow=%0b",
                   vertex, last_vertex, overflow);
      end else begin
        exp_e = tour_q.pop_front();
        if (vertex !== exp_e.vertex || last_vertex !== exp_e.last_vertex ||
            overflow !== exp_e.overflow) begin
          fails++;
          if (fails <= 10)
            $display("mismatch: vertex %0d/%0d last_vertex %0b/%0b overflow %0b/%0b (exp/act)",
                     exp_e.vertex, vertex, exp_e.last_vertex, last_vertex,
                     exp_e.overflow, overflow);
        end
      end
    end
  end

  initial begin
    rst          = 1'b1;
    key_valid    = 1'b0;
    key          = '0;
    last_key     = 1'b0;
    vertex_stall = 1'b0;
    key_taken    = 1'b0;
    held         = 0;
    dropped      = 1'b0;
    sent         = 0;
    fails        = 0;

    // single vertex runs at both key extremes
    add_fixed(32'hFFFF_FFFF, 1'b1);
    add_fixed(32'h0, 1'b1);
    // equal keys keep arrival order
    add_fixed(32'h5, 1'b0);
    add_fixed(32'h5, 1'b0);
    add_fixed(32'h5, 1'b1);
    // descending pair: tour reversed; ascending pair: tour kept in key order
    add_fixed(32'hFFFF_FFFF, 1'b0);
    add_fixed(32'h0, 1'b1);
    add_fixed(32'h0, 1'b0);
    add_fixed(32'hFFFF_FFFF, 1'b1);
    // ties mixed with reversal
    add_fixed(32'h7, 1'b0);
    add_fixed(32'h3, 1'b0);
    add_fixed(32'h7, 1'b0);
    add_fixed(32'h1, 1'b1);
    add_fixed(32'h8000_0000, 1'b0);
    add_fixed(32'h8000_0001, 1'b0);
    add_fixed(32'h7FFF_FFFF, 1'b1);

    // overflow with the closing key itself dropped, then a run at capacity
    add_run(MAX_KEYS + 2);
    add_run(MAX_KEYS);
    while (pending_keys.size() < 160) begin
      if ($urandom_range(0, 11) == 0)
        add_run($urandom_range(MAX_KEYS - 2, MAX_KEYS + 4));
      else
        add_run($urandom_range(1, 8));
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_keys.size() == 0 && !key_valid);
    wait (tour_q.size() == 0);
    repeat (16) @(posedge clk);

    if (fails == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #1600000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
